@@ sv/hv_supply_soft_start_regulator_top_assert.svh @@
// Assertion macros for the high-voltage supply soft-start regulator.
`ifndef HV_SUPPLY_SOFT_START_REGULATOR_TOP_ASSERT_SVH
`define HV_SUPPLY_SOFT_START_REGULATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define HVSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define HVSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hvss_pkg.sv @@
// Types and constants shared by the soft-start regulator files.
package hvss_pkg;

  typedef struct packed {
    logic [11:0] hv_sample;
    logic        fault;
  } hvss_in_t;

  typedef struct packed {
    logic [15:0] duty_level;
    logic [1:0]  regulator_state;
    logic [12:0] present_setpoint;
    logic [13:0] measured_level;
    logic        low_noise_mode;
  } hvss_out_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSkipCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinDuty     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxDuty     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPGain       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHvScale     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTargetLevel = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRampStep    = 3'd6;

  // Regulator control states
  localparam logic [1:0] CtlStandby  = 2'd0;
  localparam logic [1:0] CtlRamp     = 2'd1;
  localparam logic [1:0] CtlRegulate = 2'd2;

  localparam logic [13:0] SetpointMax = 14'd8191;

endpackage

@@ sv/hv_supply_soft_start_regulator_top.sv @@
// High-voltage supply soft-start regulator: tick skipper, ramp/regulate FSM, P loop.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per PWM wrap
// tick, carrying the raw HV ADC sample and the fault flag. Only every
// skip_count-th tick runs the loop; other ticks are accepted in idle and give
// no result. Output channel (out_valid_o / out_stall_i / out_data_o): one result
// per loop iteration, held in an output register.
// A loop tick steps through the measure, duty and output states. The single shared
// multiplier is used in the measure step for the voltage conversion and in the duty
// step for the proportional term; duty limiting feeds the output register in the
// output step. The next tick is taken once the sequencer is back in idle.
// While the receiver stalls, the result holds; the next tick is still taken, and
// a further loop result waits in the final step until the output register frees.
// Configuration writes (cfg_we_i / cfg_index_i / cfg_wdata_i) take effect at the
// clock edge; write only while idle.
// Reset (rst_ni low, asynchronous): registers return to their defaults, the
// regulator to standby with setpoint 0 and the mode pin low, the output empty.
module hv_supply_soft_start_regulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hvss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hvss_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hvss_pkg::hvss_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hvss_pkg::hvss_out_t           out_data_o
);
  import hvss_pkg::*;

  localparam logic [1:0] SeqIdle = 2'd0;
  localparam logic [1:0] SeqMeas = 2'd1;
  localparam logic [1:0] SeqDuty = 2'd2;
  localparam logic [1:0] SeqOut  = 2'd3;

  // Configuration registers
  logic [15:0] skip_count_q, min_duty_q, max_duty_q, p_gain_q;
  logic [17:0] hv_scale_q;
  logic [12:0] target_q;
  logic [9:0]  ramp_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_count_q <= 16'd20;
      min_duty_q   <= 16'd625;
      max_duty_q   <= 16'd5000;
      p_gain_q     <= 16'd179;
      hv_scale_q   <= 18'd110093;
      target_q     <= 13'd3900;
      ramp_step_q  <= 10'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSkipCount:   skip_count_q <= cfg_wdata_i[15:0];
        RegMinDuty:     min_duty_q   <= cfg_wdata_i[15:0];
        RegMaxDuty:     max_duty_q   <= cfg_wdata_i[15:0];
        RegPGain:       p_gain_q     <= cfg_wdata_i[15:0];
        RegHvScale:     hv_scale_q   <= cfg_wdata_i;
        RegTargetLevel: target_q     <= cfg_wdata_i[12:0];
        RegRampStep:    ramp_step_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  logic [1:0]  seq_q, seq_d;
  logic [15:0] tick_q, tick_d;
  logic [11:0] sample_q;
  logic        fault_q;
  logic [1:0]  ctl_q, ctl_d;
  logic        entry_q, entry_d;
  logic [13:0] sp_q, sp_d;
  logic        ramp_down_q, ramp_down_d;
  logic        mode_q, mode_d;
  logic [13:0] meas_q;
  logic signed [31:0] prod_q;
  logic        out_valid_q;
  hvss_out_t   out_q;

  logic in_xfer, out_free, run_tick;
  logic [15:0] tick_inc;

  assign in_stall_o = (seq_q != SeqIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tick_inc   = tick_q + 16'd1;
  assign run_tick   = (tick_inc >= skip_count_q);

  // Shared multiplier
  logic signed [16:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [35:0] mul_p;
  logic signed [14:0] err;

  assign err = $signed({1'b0, sp_q}) - $signed({1'b0, meas_q});

  always_comb begin
    if (seq_q == SeqMeas) begin
      mul_a = $signed({5'd0, sample_q});
      mul_b = $signed({1'b0, hv_scale_q});
    end else begin
      mul_a = $signed({1'b0, p_gain_q});
      mul_b = 19'(err);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Control state update, done in the measure step
  logic signed [15:0] stepped, sp_sat, diff, diff_abs;
  logic               rd;

  always_comb begin
    ctl_d       = ctl_q;
    entry_d     = entry_q;
    sp_d        = sp_q;
    ramp_down_d = ramp_down_q;
    mode_d      = mode_q;
    rd          = entry_q ? (sp_q >= {1'b0, target_q}) : ramp_down_q;
    stepped     = rd ? ($signed({2'b0, sp_q}) - $signed({6'd0, ramp_step_q}))
                     : ($signed({2'b0, sp_q}) + $signed({6'd0, ramp_step_q}));
    if (stepped < 16'sd0)
      sp_sat = 16'sd0;
    else if (stepped > $signed({2'b0, SetpointMax}))
      sp_sat = $signed({2'b0, SetpointMax});
    else
      sp_sat = stepped;
    diff     = sp_sat - $signed({3'b0, target_q});
    diff_abs = (diff < 16'sd0) ? -diff : diff;
    unique case (ctl_q)
      CtlStandby: begin
        if (entry_q) begin
          mode_d  = 1'b0;
          entry_d = 1'b0;
        end
        if (!fault_q) begin
          ctl_d   = CtlRamp;
          entry_d = 1'b1;
          sp_d    = '0;
          mode_d  = 1'b1;
        end
      end
      CtlRamp: begin
        entry_d     = 1'b0;
        ramp_down_d = rd;
        sp_d        = sp_sat[13:0];
        if (diff_abs <= $signed({6'd0, ramp_step_q})) begin
          ctl_d   = CtlRegulate;
          entry_d = 1'b1;
          sp_d    = {1'b0, target_q};
        end
        if (fault_q) begin
          ctl_d   = CtlStandby;
          entry_d = 1'b1;
        end
      end
      CtlRegulate: begin
        entry_d = 1'b0;
        if (fault_q) begin
          ctl_d   = CtlStandby;
          entry_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Duty: truncate toward zero, saturate to int16, then gate and clamp
  logic signed [31:0] prod_adj;
  logic signed [23:0] q_div;
  logic signed [16:0] duty;
  logic [15:0]        level;

  always_comb begin
    prod_adj = (prod_q < 32'sd0) ? (prod_q + 32'sd255) : prod_q;
    q_div    = 24'(prod_adj >>> 8);
    if (q_div > 24'sd32767)
      duty = 17'sd32767;
    else if (q_div < -24'sd32768)
      duty = -17'sd32768;
    else
      duty = 17'(q_div);
    if (ctl_q == CtlStandby)
      level = '0;
    else if (duty < $signed({1'b0, min_duty_q}))
      level = '0;
    else if (duty > $signed({1'b0, max_duty_q}))
      level = max_duty_q;
    else
      level = duty[15:0];
  end

  always_comb begin
    seq_d  = seq_q;
    tick_d = tick_q;
    unique case (seq_q)
      SeqIdle: begin
        if (in_xfer) begin
          tick_d = run_tick ? '0 : tick_inc;
          if (run_tick) seq_d = SeqMeas;
        end
      end
      SeqMeas: seq_d = SeqDuty;
      SeqDuty: seq_d = SeqOut;
      SeqOut:  if (out_free) seq_d = SeqIdle;
      default: seq_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SeqIdle;
      tick_q      <= '0;
      ctl_q       <= CtlStandby;
      entry_q     <= 1'b1;
      sp_q        <= '0;
      ramp_down_q <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      tick_q <= tick_d;
      if (seq_q == SeqMeas) begin
        ctl_q       <= ctl_d;
        entry_q     <= entry_d;
        sp_q        <= sp_d;
        ramp_down_q <= ramp_down_d;
        mode_q      <= mode_d;
      end
      if (seq_q == SeqOut && out_free)
        out_valid_q <= 1'b1;
      else if (!out_stall_i)
        out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= in_data_i.hv_sample;
      fault_q  <= in_data_i.fault;
    end
    if (seq_q == SeqMeas) meas_q <= mul_p[29:16];
    if (seq_q == SeqDuty) prod_q <= mul_p[31:0];
    if (seq_q == SeqOut && out_free) begin
      out_q.duty_level       <= level;
      out_q.regulator_state  <= ctl_q;
      out_q.present_setpoint <= sp_q[12:0];
      out_q.measured_level   <= meas_q;
      out_q.low_noise_mode   <= mode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/hvss_chk.sv @@
// Port-level checker for the soft-start regulator, bound to the top level.
`include "hv_supply_soft_start_regulator_top_assert.svh"

module hvss_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [hvss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [hvss_pkg::CfgDataW-1:0] cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input hvss_pkg::hvss_in_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input hvss_pkg::hvss_out_t           out_data_o
);
  import hvss_pkg::*;

  // Hold a stalled result
  `HVSS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Standby results never drive the PWM
  `HVSS_ASSERT_IMP(a_standby_duty, out_valid_o && out_data_o.regulator_state == CtlStandby, out_data_o.duty_level == 16'd0, "duty non-zero in standby")

  // Ramping or regulating always runs in low-noise mode
  `HVSS_ASSERT_IMP(a_run_mode, out_valid_o && out_data_o.regulator_state != CtlStandby, out_data_o.low_noise_mode, "PFM mode while running")

  // A new result only follows a busy loop iteration
  `HVSS_ASSERT_IMP(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o), "result without loop iteration")

endmodule

bind hv_supply_soft_start_regulator_top hvss_chk u_hvss_chk (.*);

@@ verif/hv_supply_soft_start_regulator_top_test.sv @@
// Self-checking bench for the soft-start regulator: directed table, then random phases.
`timescale 1ns / 100ps

module hv_supply_soft_start_regulator_top_test;
  import hvss_pkg::*;

  typedef enum logic {RowTick, RowWrite} row_kind_e;
  typedef enum int {StallNone, StallLight, StallHeavy, StallToggle} stall_mode_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    int                  value;
    hvss_in_t            tick;
    bit                  known;
    hvss_out_t           want;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  hvss_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hvss_out_t           out_data;

  // register shadows, at their reset values
  int r_skip   = 20;
  int r_min    = 625;
  int r_max    = 5000;
  int r_gain   = 179;
  int r_scale  = 110093;
  int r_target = 3900;
  int r_step   = 1;

  // regulator state as the block should hold it
  logic [1:0] st_ctrl     = CtlStandby;
  bit         st_entry    = 1'b1;
  int         st_ticks    = 0;
  int         st_setpoint = 0;
  bit         st_down     = 1'b0;
  bit         st_mode     = 1'b0;

  hvss_out_t   pending_results[$];
  stim_row_t   table_rows[$];
  int          n_errors  = 0;
  int          n_ticks   = 0;
  int          n_results = 0;
  int          n_writes  = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = StallNone;

  hv_supply_soft_start_regulator_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  // One PWM wrap tick; returns 1 when the control loop ran and gave a result.
  function automatic bit regulator_step(input hvss_in_t t, output hvss_out_t r);
    longint prod;
    int     measured;
    int     sp_gap;
    longint duty;
    int     level;
    r = '0;
    st_ticks = (st_ticks + 1) & 'hFFFF;
    if (st_ticks < r_skip) return 1'b0;
    st_ticks = 0;
    prod = longint'(t.hv_sample) * longint'(r_scale);
    measured = int'(prod >>> 16);
    case (st_ctrl)
      CtlStandby: begin
        if (st_entry) begin
          st_mode  = 1'b0;
          st_entry = 1'b0;
        end
        if (!t.fault) begin
          st_ctrl     = CtlRamp;
          st_entry    = 1'b1;
          st_setpoint = 0;
          st_mode     = 1'b1;
        end
      end
      CtlRamp: begin
        if (st_entry) begin
          st_entry = 1'b0;
          st_down  = (st_setpoint >= r_target);
        end
        st_setpoint = st_down ? st_setpoint - r_step : st_setpoint + r_step;
        if (st_setpoint < 0) st_setpoint = 0;
        if (st_setpoint > int'(SetpointMax)) st_setpoint = int'(SetpointMax);
        sp_gap = st_setpoint - r_target;
        if (sp_gap < 0) sp_gap = -sp_gap;
        // snap onto the target once within one step
        if (sp_gap <= r_step) begin
          st_ctrl     = CtlRegulate;
          st_entry    = 1'b1;
          st_setpoint = r_target;
        end
        if (t.fault) begin
          st_ctrl  = CtlStandby;
          st_entry = 1'b1;
        end
      end
      CtlRegulate: begin
        st_entry = 1'b0;
        if (t.fault) begin
          st_ctrl  = CtlStandby;
          st_entry = 1'b1;
        end
      end
      default: ;
    endcase
    // signed division truncates toward zero
    duty = (longint'(r_gain) * longint'(st_setpoint - measured)) / 256;
    if (duty > 32767) duty = 32767;
    if (duty < -32768) duty = -32768;
    if (st_ctrl == CtlStandby) level = 0;
    else if (duty < r_min) level = 0;
    else if (duty > r_max) level = r_max;
    else level = int'(duty);
    r.duty_level       = 16'(level);
    r.regulator_state  = st_ctrl;
    r.present_setpoint = 13'(st_setpoint);
    r.measured_level   = 14'(measured);
    r.low_noise_mode   = st_mode;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(input hvss_out_t got);
    hvss_out_t want;
    n_results++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", got, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.duty_level != want.duty_level)
      report_mismatch("duty_level", got.duty_level, want.duty_level);
    if (got.regulator_state != want.regulator_state)
      report_mismatch("regulator_state", got.regulator_state, want.regulator_state);
    if (got.present_setpoint != want.present_setpoint)
      report_mismatch("present_setpoint", got.present_setpoint, want.present_setpoint);
    if (got.measured_level != want.measured_level)
      report_mismatch("measured_level", got.measured_level, want.measured_level);
    if (got.low_noise_mode != want.low_noise_mode)
      report_mismatch("low_noise_mode", got.low_noise_mode, want.low_noise_mode);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // receiver back-pressure: pick a new random stall pattern whenever the current run ends
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 99) < 30);
      StallHeavy: out_stall <= ($urandom_range(0, 99) < 85);
      default:    out_stall <= ~out_stall;
    endcase
  end

  // Hold until every result is back, then let a skipped tick drain.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegSkipCount:   r_skip   = value & 'hFFFF;
      RegMinDuty:     r_min    = value & 'hFFFF;
      RegMaxDuty:     r_max    = value & 'hFFFF;
      RegPGain:       r_gain   = value & 'hFFFF;
      RegHvScale:     r_scale  = value & 'h3FFFF;
      RegTargetLevel: r_target = value & 'h1FFF;
      RegRampStep:    r_step   = value & 'h3FF;
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  // Present one tick and hold it until the transfer; returns at the accepting edge.
  task automatic send_tick(input hvss_in_t t, input bit known, input hvss_out_t want);
    hvss_out_t r;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    n_ticks++;
    if (regulator_step(t, r)) pending_results.push_back(known ? want : r);
  endtask

  task automatic add_tick(input int sample, input bit fault);
    stim_row_t row;
    row.kind = RowTick;
    row.idx = '0;
    row.value = 0;
    row.tick.hv_sample = 12'(sample);
    row.tick.fault = fault;
    row.known = 1'b0;
    row.want = '0;
    table_rows.push_back(row);
  endtask

  task automatic add_known(input int sample, input bit fault, input hvss_out_t want);
    add_tick(sample, fault);
    table_rows[$].known = 1'b1;
    table_rows[$].want = want;
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input int value);
    stim_row_t row;
    row.kind = RowWrite;
    row.idx = idx;
    row.value = value;
    row.tick = '0;
    row.known = 1'b0;
    row.want = '0;
    table_rows.push_back(row);
  endtask

  function automatic int pick_value(input int lo, input int hi, input int typ_hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, typ_hi);
    endcase
  endfunction

  task automatic shuffle_config();
    int sel;
    settle();
    sel = $urandom_range(0, 9);
    if (sel < 6) write_reg(RegSkipCount, $urandom_range(0, 3));
    else if (sel < 9) write_reg(RegSkipCount, $urandom_range(4, 24));
    else write_reg(RegSkipCount, 20);
    write_reg(RegMinDuty, pick_value(0, 65535, 2000));
    write_reg(RegMaxDuty, pick_value(0, 65535, 20000));
    write_reg(RegPGain, pick_value(0, 65535, 2000));
    write_reg(RegHvScale, pick_value(0, 262143, 262143));
    write_reg(RegTargetLevel, pick_value(0, 8191, 6600));
    write_reg(RegRampStep, pick_value(0, 1023, 1000));
  endtask

  // Bursts of ticks with random gaps unless no_gaps is set; faults are rare so ramps can finish.
  task automatic run_ticks(input int count, input bit no_gaps);
    hvss_in_t t;
    int       burst;
    int       gap;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      t.hv_sample = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                                 : 12'($urandom_range(0, 4095));
      t.fault = ($urandom_range(0, 99) < 8);
      send_tick(t, 1'b0, '0);
      burst--;
      if (burst == 0 || i == count - 1) begin
        burst = $urandom_range(1, 16);
        gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0 || i == count - 1) in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_write(RegSkipCount, 0);
    add_write(RegRampStep, 1000);
    add_known(0, 1'b1, '{16'd0, CtlStandby, 13'd0, 14'd0, 1'b0});
    add_known(4095, 1'b0, '{16'd0, CtlRamp, 13'd0, 14'd6879, 1'b1});
    add_known(0, 1'b0, '{16'd699, CtlRamp, 13'd1000, 14'd0, 1'b1});
    add_tick(0, 1'b0);
    add_tick(0, 1'b0);
    add_tick(0, 1'b0);
    add_tick(4095, 1'b0);
    add_write(RegPGain, 65535);
    add_tick(0, 1'b0);
    add_write(RegMaxDuty, 65535);
    add_tick(0, 1'b0);
    add_write(RegMinDuty, 0);
    add_write(RegHvScale, 262143);
    add_tick(4095, 1'b0);
    add_known(0, 1'b1, '{16'd0, CtlStandby, 13'd3900, 14'd0, 1'b1});
    add_known(4095, 1'b1, '{16'd0, CtlStandby, 13'd3900, 14'd16379, 1'b0});
    // ramp down from a setpoint already on a zero target
    add_write(RegTargetLevel, 0);
    add_tick(0, 1'b0);
    add_tick(0, 1'b0);
    // a zero step never moves the setpoint
    add_write(RegTargetLevel, 8191);
    add_write(RegRampStep, 0);
    add_tick(0, 1'b1);
    add_tick(0, 1'b0);
    add_tick(0, 1'b0);
    add_tick(0, 1'b0);
    // target moved behind a running ramp: the direction holds
    add_write(RegRampStep, 1000);
    add_tick(0, 1'b0);
    add_write(RegTargetLevel, 0);
    add_tick(0, 1'b0);
    add_write(RegSkipCount, 2);
    add_tick(1234, 1'b0);
    add_tick(2345, 1'b0);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == RowWrite) begin
        in_valid <= 1'b0;
        settle();
        write_reg(table_rows[i].idx, table_rows[i].value);
      end else begin
        send_tick(table_rows[i].tick, table_rows[i].known, table_rows[i].want);
      end
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < 12; phase++) begin
      shuffle_config();
      run_ticks($urandom_range(55, 75), 1'b0);
    end

    // longest skip: a back-to-back burst that never reaches a loop run
    settle();
    write_reg(RegSkipCount, 65535);
    run_ticks(20, 1'b1);

    for (int w = 0; w < 2000 && pending_results.size() != 0; w++) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    repeat (16) @(posedge clk);

    $display("Drove %0d wrap ticks and %0d register writes; %0d loop results checked.",
             n_ticks, n_writes, n_results);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches seen.", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
